/* rtl/slist_pkg.sv */
// shared types, codes and constants of the sequential list engine
package slist_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 64;

  // fixed field widths of the beats
  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 8;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 6;
  localparam int COUNT_W = 7;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_INSERT  = 3'd1,
    CMD_DEL_IDX = 3'd2,
    CMD_READ    = 3'd3,
    CMD_FIND    = 3'd4,
    CMD_DEL_VAL = 3'd5,
    CMD_MIN     = 3'd6,
    CMD_INS_MAX = 3'd7
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_PUT,
    S_DONE
  } state_t;

endpackage

/* rtl/sequential_list_engine_unit.sv */
// top level of the sequential list engine: sequencer, count register and element ram
// one command at a time: in_stall is high from acceptance until the result is loaded into the
// output register (which may still wait on out_stall); the next is taken in the cycle after.
// clear and errors go straight to the result; inserts shift the tail up from the top, then write
// the new element; read, delete at index, find, delete value and minimum scan the list forward;
// insert after max scans for the maximum, then shifts and inserts behind it; scans and shifts move
// one element per cycle through the single ram read and write port pair.
// reset (synchronous, active high) empties the list; the ram itself is not cleared.
module sequential_list_engine_unit #(
  parameter int CAPACITY = slist_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [slist_pkg::CMD_W-1:0]  cmd,
  input  logic [slist_pkg::POS_W-1:0]  position,
  input  logic [slist_pkg::VAL_W-1:0]  item_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [slist_pkg::STAT_W-1:0] status,
  output logic [slist_pkg::VAL_W-1:0]  read_value,
  output logic [slist_pkg::FIDX_W-1:0] found_index,
  output logic [slist_pkg::COUNT_W-1:0] removed_count,
  output logic [slist_pkg::COUNT_W-1:0] list_count,
  output logic                         is_empty,
  output logic                         is_full
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > slist_pkg::POS_W) ? CW : slist_pkg::POS_W;
  localparam int VW = slist_pkg::VAL_W;

  // control registers
  slist_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic          pend, pend_next;

  // work registers
  slist_pkg::cmd_t    cmd_r, cmd_r_next;
  slist_pkg::status_t stat, stat_next;
  logic [VW-1:0] val_r, val_r_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] at, at_next;
  logic [CW-1:0] scan_end, scan_end_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] removed, removed_next;
  logic [AW-1:0] best, best_next;
  logic [VW-1:0] best_v, best_v_next;
  logic          found, found_next;
  logic [AW-1:0] fidx, fidx_next;
  logic [VW-1:0] rdval, rdval_next;

  // ram port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  logic          out_load;
  logic          slot_free;
  logic          full;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] idx_dec;

  slist_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state != slist_pkg::S_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign full      = (count == CW'(CAPACITY));
  assign pos_x     = XW'(position);
  assign cnt_x     = XW'(count);
  assign idx_dec   = idx - 1'b1;

  // sequencer: next state, work registers and ram accesses
  always_comb begin
    state_next    = state;
    count_next    = count;
    pend_next     = pend;
    cmd_r_next    = cmd_r;
    stat_next     = stat;
    val_r_next    = val_r;
    idx_next      = idx;
    at_next       = at;
    scan_end_next = scan_end;
    pend_idx_next = pend_idx;
    k_next        = k;
    removed_next  = removed;
    best_next     = best;
    best_v_next   = best_v;
    found_next    = found;
    fidx_next     = fidx;
    rdval_next    = rdval;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;
    out_load      = 1'b0;

    unique case (state)
      slist_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_r_next   = slist_pkg::cmd_t'(cmd);
          val_r_next   = item_value;
          stat_next    = slist_pkg::ST_OK;
          rdval_next   = '0;
          fidx_next    = '0;
          removed_next = '0;
          found_next   = 1'b0;
          k_next       = '0;
          best_next    = '0;
          best_v_next  = '0;
          pend_next    = 1'b0;
          state_next   = slist_pkg::S_DONE;
          unique case (slist_pkg::cmd_t'(cmd)) inside
            slist_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            slist_pkg::CMD_INSERT: begin
              if (full) begin
                stat_next = slist_pkg::ST_FULL;
              end else if (pos_x > cnt_x) begin
                stat_next = slist_pkg::ST_RANGE;
              end else begin
                at_next    = CW'(position);
                idx_next   = count;
                state_next = slist_pkg::S_SHUP;
              end
            end
            default: begin
              if (count == '0) begin
                stat_next = slist_pkg::ST_EMPTY;
              end else begin
                unique case (slist_pkg::cmd_t'(cmd)) inside
                  slist_pkg::CMD_DEL_IDX, slist_pkg::CMD_READ: begin
                    if (pos_x >= cnt_x) begin
                      stat_next = slist_pkg::ST_RANGE;
                    end else begin
                      at_next       = CW'(position);
                      idx_next      = CW'(position);
                      scan_end_next = (slist_pkg::cmd_t'(cmd) == slist_pkg::CMD_READ) ?
                                      CW'(position) + 1'b1 : count;
                      state_next    = slist_pkg::S_SCAN;
                    end
                  end
                  slist_pkg::CMD_INS_MAX: begin
                    if (full) begin
                      stat_next = slist_pkg::ST_FULL;
                    end else begin
                      idx_next      = '0;
                      scan_end_next = count;
                      state_next    = slist_pkg::S_SCAN;
                    end
                  end
                  default: begin
                    idx_next      = '0;
                    scan_end_next = count;
                    state_next    = slist_pkg::S_SCAN;
                  end
                endcase
              end
            end
          endcase
        end
      end

      slist_pkg::S_SCAN: begin
        // issue the next forward read
        if (idx < scan_end) begin
          ram_raddr     = idx[AW-1:0];
          pend_next     = 1'b1;
          pend_idx_next = idx[AW-1:0];
          idx_next      = idx + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        // act on the element read last cycle
        if (pend) begin
          case (cmd_r)
            slist_pkg::CMD_DEL_IDX: begin
              if (pend_idx == at[AW-1:0]) begin
                rdval_next = ram_rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_idx - 1'b1;
                ram_wdata = ram_rdata;
              end
            end
            slist_pkg::CMD_READ: begin
              rdval_next = ram_rdata;
            end
            slist_pkg::CMD_FIND: begin
              if (ram_rdata == val_r && !found) begin
                found_next = 1'b1;
                fidx_next  = pend_idx;
              end
            end
            slist_pkg::CMD_DEL_VAL: begin
              if (ram_rdata == val_r) begin
                removed_next = removed + 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = k[AW-1:0];
                ram_wdata = ram_rdata;
                k_next    = k + 1'b1;
              end
            end
            slist_pkg::CMD_MIN: begin
              if (pend_idx == '0 || ram_rdata <= best_v) begin
                best_next   = pend_idx;
                best_v_next = ram_rdata;
              end
            end
            slist_pkg::CMD_INS_MAX: begin
              if (pend_idx == '0 || ram_rdata >= best_v) begin
                best_next   = pend_idx;
                best_v_next = ram_rdata;
              end
            end
            default: ;
          endcase
        end
        // scan finished: settle the command
        if (idx >= scan_end && !pend) begin
          state_next = slist_pkg::S_DONE;
          case (cmd_r)
            slist_pkg::CMD_DEL_IDX: begin
              count_next = count - 1'b1;
            end
            slist_pkg::CMD_FIND: begin
              stat_next = found ? slist_pkg::ST_OK : slist_pkg::ST_NOT_FOUND;
            end
            slist_pkg::CMD_DEL_VAL: begin
              count_next = k;
              stat_next  = (removed == '0) ? slist_pkg::ST_NOT_FOUND : slist_pkg::ST_OK;
            end
            slist_pkg::CMD_MIN: begin
              fidx_next = best;
            end
            slist_pkg::CMD_INS_MAX: begin
              at_next    = CW'(best) + 1'b1;
              idx_next   = count;
              state_next = slist_pkg::S_SHUP;
            end
            default: ;
          endcase
        end
      end

      slist_pkg::S_SHUP: begin
        // read downward from the top, write one place higher in the next cycle
        if (idx > at) begin
          ram_raddr     = idx_dec[AW-1:0];
          pend_next     = 1'b1;
          pend_idx_next = idx_dec[AW-1:0];
          idx_next      = idx_dec;
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx + 1'b1;
          ram_wdata = ram_rdata;
        end
        if (idx <= at && !pend) begin
          state_next = slist_pkg::S_PUT;
        end
      end

      slist_pkg::S_PUT: begin
        // place the new element in the opened gap
        ram_we     = 1'b1;
        ram_waddr  = at[AW-1:0];
        ram_wdata  = val_r;
        count_next = count + 1'b1;
        state_next = slist_pkg::S_DONE;
      end

      slist_pkg::S_DONE: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = slist_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = slist_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slist_pkg::S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // work and output payload
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    stat     <= stat_next;
    val_r    <= val_r_next;
    idx      <= idx_next;
    at       <= at_next;
    scan_end <= scan_end_next;
    pend_idx <= pend_idx_next;
    k        <= k_next;
    removed  <= removed_next;
    best     <= best_next;
    best_v   <= best_v_next;
    found    <= found_next;
    fidx     <= fidx_next;
    rdval    <= rdval_next;
    if (out_load) begin
      status        <= stat;
      read_value    <= rdval;
      found_index   <= slist_pkg::FIDX_W'(fidx);
      removed_count <= slist_pkg::COUNT_W'(removed);
      list_count    <= slist_pkg::COUNT_W'(count);
      is_empty      <= (count == '0);
      is_full       <= full;
    end
  end

endmodule

/* rtl/slist_ram.sv */
// generic single-write, single-read ram with registered read data
module slist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/slist_checker.sv */
// port-level assertions for the sequential list engine, bound to the top level
module slist_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [slist_pkg::STAT_W-1:0]  status,
  input logic [slist_pkg::VAL_W-1:0]   read_value,
  input logic [slist_pkg::FIDX_W-1:0]  found_index,
  input logic [slist_pkg::COUNT_W-1:0] removed_count,
  input logic [slist_pkg::COUNT_W-1:0] list_count,
  input logic                          is_empty,
  input logic                          is_full
);

  // one command at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in progress");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({status, read_value, found_index, removed_count, list_count, is_empty, is_full}))
    else $error("result beat changed under stall");

  // empty list shows zero count and is not full
  a_empty_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> list_count == '0 && !is_full)
    else $error("empty flag disagrees with count");

  // full status only on a full list
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == slist_pkg::ST_FULL |-> is_full)
    else $error("full status on a list that is not full");

  // empty status only on an empty list
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == slist_pkg::ST_EMPTY |-> is_empty)
    else $error("empty status on a list that is not empty");

endmodule

bind sequential_list_engine_unit slist_checker u_slist_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .read_value    (read_value),
  .found_index   (found_index),
  .removed_count (removed_count),
  .list_count    (list_count),
  .is_empty      (is_empty),
  .is_full       (is_full)
);
